### sv/iqws_pkg.sv
// Shared types and constants for the issue queue wakeup/select block.
// No dependencies; used by every other file in this folder except iqws_ram.
`timescale 1ns / 1ps

package iqws_pkg;

   // Fixed field widths of the request and response channels
   localparam int ID_W        = 6;
   localparam int LAT_W       = 4;
   localparam int CNT_W       = 7;
   localparam int SRC_CNT_W   = 2;
   localparam int MAX_SOURCES = 2;
   localparam int COMPLETE_LANES = 4;

   // Default queue depth and ready-scan width
   localparam int DEF_ENTRIES  = 64;
   localparam int SCAN_GROUP   = 8;
   localparam int GRP_BIT_W    = $clog2(SCAN_GROUP);

   // Request operation codes
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // Controller to datapath commands
   typedef struct packed {
      logic take_load;
      logic take_tick;
      logic scan_step;
      logic finish;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic scan_hit;
      logic scan_last;
   } status_type;

endpackage

### sv/iqws_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module iqws_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/iqws_ctrl.sv
// Controller for the issue queue: request handshake, scan sequencing and
// response valid. Depends on iqws_pkg.
`timescale 1ns / 1ps

module iqws_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_operation,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output iqws_pkg::cmd_type    cmd,
   input  iqws_pkg::status_type status
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      take;

   // Accept only when idle and out of reset
   assign req_stall = reset || (state_ff != ST_IDLE);
   assign take      = req_valid && !req_stall;

   // Commands to the datapath
   always_comb begin
      cmd.take_load = take && (req_operation == iqws_pkg::OP_LOAD);
      cmd.take_tick = take && (req_operation == iqws_pkg::OP_TICK);
      cmd.scan_step = (state_ff == ST_SCAN);
      cmd.finish    = (state_ff == ST_FINISH) && (!rsp_valid_ff || !rsp_stall);
   end

   // Next state and response valid
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.take_tick) begin
               state_in = ST_SCAN;
            end else if (cmd.take_load) begin
               state_in = ST_FINISH;
            end
         end
         ST_SCAN: begin
            if (status.scan_hit || status.scan_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (cmd.finish) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state and the response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### sv/iqws_datapath.sv
// Datapath of the issue queue: entry tags, pending/issued/completed bits,
// completion wakeup, grouped ready scan and response registers.
// Depends on iqws_pkg and iqws_ram.
`timescale 1ns / 1ps

module iqws_datapath #(
   parameter int ENTRIES = iqws_pkg::DEF_ENTRIES
) (
   input  logic                                clock,
   input  logic                                reset,
   input  iqws_pkg::cmd_type                    cmd,
   output iqws_pkg::status_type                 status,
   input  logic                                csr_write,
   input  logic [iqws_pkg::CNT_W-1:0]          csr_entry_count,
   input  logic [iqws_pkg::ID_W-1:0]           req_entry_index,
   input  logic [iqws_pkg::LAT_W-1:0]          req_entry_latency,
   input  logic [iqws_pkg::SRC_CNT_W-1:0]      req_source_count,
   input  logic [iqws_pkg::ID_W-1:0]           req_source_a,
   input  logic [iqws_pkg::ID_W-1:0]           req_source_b,
   input  logic [iqws_pkg::COMPLETE_LANES-1:0] req_done_mask,
   input  logic [iqws_pkg::ID_W-1:0]           req_done_id0,
   input  logic [iqws_pkg::ID_W-1:0]           req_done_id1,
   input  logic [iqws_pkg::ID_W-1:0]           req_done_id2,
   input  logic [iqws_pkg::ID_W-1:0]           req_done_id3,
   input  logic                                req_out_ready,
   output logic                                rsp_issue_valid,
   output logic [iqws_pkg::ID_W-1:0]           rsp_issue_id,
   output logic [iqws_pkg::LAT_W-1:0]          rsp_issue_latency,
   output logic                                rsp_woke_this_tick,
   output logic                                rsp_stalled,
   output logic                                rsp_all_issued,
   output logic                                rsp_all_completed
);

   localparam int IDX_W  = $clog2(ENTRIES);
   localparam int LIVE_W = $clog2(ENTRIES + 1);
   localparam int WIDE_W = (LIVE_W > iqws_pkg::CNT_W) ? LIVE_W : iqws_pkg::CNT_W;
   localparam int NGRP   = (ENTRIES + iqws_pkg::SCAN_GROUP - 1) / iqws_pkg::SCAN_GROUP;
   localparam int GRP_W  = (NGRP > 1) ? $clog2(NGRP) : 1;
   localparam int LANES  = iqws_pkg::COMPLETE_LANES;
   localparam int NSRC   = iqws_pkg::MAX_SOURCES;
   localparam int ID_W   = iqws_pkg::ID_W;
   localparam int GB_W   = iqws_pkg::GRP_BIT_W;

   // Lowest set bit of one scan group
   function automatic logic [GB_W-1:0] first_set(
      input logic [iqws_pkg::SCAN_GROUP-1:0] v
   );
      logic [GB_W-1:0] pos;
      pos = '0;
      for (int i = iqws_pkg::SCAN_GROUP - 1; i >= 0; i--) begin
         if (v[i]) begin
            pos = GB_W'(i);
         end
      end
      return pos;
   endfunction

   // Configuration and counters
   logic [iqws_pkg::CNT_W-1:0] count_ff;
   logic [LIVE_W-1:0]          live;
   logic [LIVE_W-1:0]          issued_total_ff;
   logic [LIVE_W-1:0]          issued_total_in;
   logic [LIVE_W-1:0]          completed_total_ff;

   // Per-entry state
   logic [ID_W-1:0]   tag_ff     [ENTRIES][NSRC];
   logic [NSRC-1:0]   pend_ff    [ENTRIES];
   logic [NSRC-1:0]   pend_in    [ENTRIES];
   logic [ENTRIES-1:0] issued_ff;
   logic [ENTRIES-1:0] completed_ff;
   logic [ENTRIES-1:0] comp_set;
   logic [ENTRIES-1:0] woke_ff;
   logic [ENTRIES-1:0] woke_in;
   logic [ENTRIES-1:0] entry_live;
   logic [NGRP*iqws_pkg::SCAN_GROUP-1:0] ready_pad;

   // Completion lanes
   logic [ID_W-1:0]  lane_id  [LANES];
   logic [IDX_W-1:0] lane_idx [LANES];
   logic [LANES-1:0] lane_new;

   // Load side
   logic [ID_W-1:0]            src_id  [NSRC];
   logic [NSRC-1:0]            load_pend;
   logic [iqws_pkg::SRC_CNT_W-1:0] src_cnt;
   logic [IDX_W-1:0]           load_idx;
   logic                       load_in_store;

   // Scan and issue
   logic [GRP_W-1:0]                   grp_ff;
   logic [iqws_pkg::SCAN_GROUP-1:0]    scan_slice;
   logic [IDX_W-1:0]                   scan_sel;
   logic [IDX_W-1:0]                   sel_ff;
   logic                               found_ff;
   logic                               out_ready_ff;
   logic                               issue;
   logic [iqws_pkg::LAT_W-1:0]         ram_rdata;

   // Clamp the entry count to the queue depth
   always_comb begin
      if (WIDE_W'(count_ff) > WIDE_W'(ENTRIES)) begin
         live = LIVE_W'(ENTRIES);
      end else begin
         live = LIVE_W'(count_ff);
      end
   end

   // Decide which completion lanes carry a fresh id
   assign lane_id[0] = req_done_id0;
   assign lane_id[1] = req_done_id1;
   assign lane_id[2] = req_done_id2;
   assign lane_id[3] = req_done_id3;

   always_comb begin
      logic dup;
      for (int k = 0; k < LANES; k++) begin
         lane_idx[k] = IDX_W'(lane_id[k]);
         dup = 1'b0;
         for (int j = 0; j < k; j++) begin
            if (req_done_mask[j] && (lane_id[j] == lane_id[k])) begin
               dup = 1'b1;
            end
         end
         lane_new[k] = req_done_mask[k] && !dup
                       && (WIDE_W'(lane_id[k]) < WIDE_W'(live))
                       && !completed_ff[lane_idx[k]];
      end
   end

   // Pending bits for a loaded entry
   assign src_id[0]     = req_source_a;
   assign src_id[1]     = req_source_b;
   assign load_idx      = IDX_W'(req_entry_index);
   assign load_in_store = WIDE_W'(req_entry_index) < WIDE_W'(ENTRIES);

   always_comb begin
      src_cnt = req_source_count;
      if (src_cnt > iqws_pkg::SRC_CNT_W'(NSRC)) begin
         src_cnt = iqws_pkg::SRC_CNT_W'(NSRC);
      end
      for (int k = 0; k < NSRC; k++) begin
         load_pend[k] = (iqws_pkg::SRC_CNT_W'(k) < src_cnt)
                        && !((WIDE_W'(src_id[k]) < WIDE_W'(ENTRIES))
                             && completed_ff[IDX_W'(src_id[k])]);
      end
   end

   // Per-entry wakeup, load and completion marking
   for (genvar e = 0; e < ENTRIES; e++) begin : g_entry
      logic load_hit;

      assign entry_live[e] = LIVE_W'(e) < live;
      assign load_hit      = cmd.take_load && load_in_store && (load_idx == IDX_W'(e));

      always_comb begin
         pend_in[e] = pend_ff[e];
         if (cmd.take_tick && entry_live[e]) begin
            for (int j = 0; j < NSRC; j++) begin
               for (int k = 0; k < LANES; k++) begin
                  if (lane_new[k] && (tag_ff[e][j] == lane_id[k])) begin
                     pend_in[e][j] = 1'b0;
                  end
               end
            end
         end
         if (load_hit) begin
            pend_in[e] = load_pend;
         end
         woke_in[e] = (pend_ff[e] != '0) && (pend_in[e] == '0);
      end

      always_comb begin
         comp_set[e] = 1'b0;
         for (int k = 0; k < LANES; k++) begin
            if (lane_new[k] && (lane_idx[k] == IDX_W'(e))) begin
               comp_set[e] = 1'b1;
            end
         end
      end

      // Tags carry no reset; pending bits do
      always_ff @(posedge clock) begin
         if (load_hit) begin
            for (int k = 0; k < NSRC; k++) begin
               tag_ff[e][k] <= (iqws_pkg::SRC_CNT_W'(k) < src_cnt) ? src_id[k] : '0;
            end
         end
         if (cmd.take_tick) begin
            woke_ff[e] <= woke_in[e];
         end
         if (reset) begin
            pend_ff[e] <= '0;
         end else begin
            pend_ff[e] <= pend_in[e];
         end
      end

      // Entry is ready once live, not issued and with nothing pending
      assign ready_pad[e] = entry_live[e] && !issued_ff[e] && (pend_ff[e] == '0);
   end

   // Pad the ready vector up to whole scan groups
   if (NGRP * iqws_pkg::SCAN_GROUP > ENTRIES) begin : g_pad
      assign ready_pad[NGRP*iqws_pkg::SCAN_GROUP-1:ENTRIES] = '0;
   end

   // Scan one group of entries per cycle
   assign scan_slice       = ready_pad[grp_ff*iqws_pkg::SCAN_GROUP +: iqws_pkg::SCAN_GROUP];
   assign scan_sel         = IDX_W'({grp_ff, first_set(scan_slice)});
   assign status.scan_hit  = |scan_slice;
   assign status.scan_last = (grp_ff == GRP_W'(NGRP - 1));

   assign issue = found_ff && out_ready_ff;

   always_comb begin
      issued_total_in = issued_total_ff;
      if (cmd.finish && issue) begin
         issued_total_in = issued_total_ff + LIVE_W'(1);
      end
   end

   // Control registers: config, bits, totals, scan position
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff           <= '0;
         issued_ff          <= '0;
         completed_ff       <= '0;
         issued_total_ff    <= '0;
         completed_total_ff <= '0;
         grp_ff             <= '0;
         found_ff           <= 1'b0;
      end else begin
         if (csr_write) begin
            count_ff <= csr_entry_count;
         end
         if (cmd.take_tick) begin
            completed_ff       <= completed_ff | comp_set;
            completed_total_ff <= completed_total_ff + LIVE_W'($countones(lane_new));
         end
         if (cmd.take_load || cmd.take_tick) begin
            grp_ff   <= '0;
            found_ff <= 1'b0;
         end else if (cmd.scan_step) begin
            if (status.scan_hit) begin
               found_ff <= 1'b1;
            end else if (!status.scan_last) begin
               grp_ff <= grp_ff + GRP_W'(1);
            end
         end
         if (cmd.finish && issue) begin
            issued_ff[sel_ff] <= 1'b1;
         end
         issued_total_ff <= issued_total_in;
      end
   end

   // Payload registers: selected entry and the tick's downstream ready
   always_ff @(posedge clock) begin
      if (cmd.take_tick) begin
         out_ready_ff <= req_out_ready;
      end
      if (cmd.scan_step && status.scan_hit) begin
         sel_ff <= scan_sel;
      end
   end

   // Latency store, read as the selected entry is found
   iqws_ram #(
      .WIDTH (iqws_pkg::LAT_W),
      .DEPTH (ENTRIES)
   ) u_lat_ram (
      .clock   (clock),
      .wr_en   (cmd.take_load && load_in_store),
      .wr_addr (load_idx),
      .wr_data (req_entry_latency),
      .rd_en   (cmd.scan_step && status.scan_hit),
      .rd_addr (scan_sel),
      .rd_data (ram_rdata)
   );

   // Response payload, loaded on the finishing transfer
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_issue_valid    <= issue;
         rsp_issue_id       <= issue ? ID_W'(sel_ff) : '0;
         rsp_issue_latency  <= issue ? ram_rdata : '0;
         rsp_woke_this_tick <= issue && woke_ff[sel_ff];
         rsp_stalled        <= found_ff && !out_ready_ff;
         rsp_all_issued     <= (issued_total_in == live);
         rsp_all_completed  <= (completed_total_ff == live);
      end
   end

endmodule

### sv/issue_queue_wakeup_select_top.sv
// Issue queue with completion wakeup and lowest-index select: top level.
// Depends on iqws_pkg, iqws_ctrl, iqws_datapath and iqws_ram.
`timescale 1ns / 1ps

// One item is taken at a time. A load goes from idle to the finish state,
// and a tick first passes through the scan state, where the ready scan
// checks eight entries per cycle and stops at the first group holding a
// ready entry or at the last group. In the finish state the response
// register is loaded once any earlier response has transferred, and the
// queue returns to idle, ready for the next request transfer. Completions of
// a tick are applied on the request transfer itself, and the stored latency
// is read from a RAM with one write port and one registered read port as the
// entry is found. A request can be taken while the previous response is
// still stalled; its own response then waits until that one has transferred.
// Request and configuration ports are held off during reset. The entry count
// register may be written at any other time but should only change while the
// queue is idle.
module issue_queue_wakeup_select_top #(
   parameter int ENTRIES = iqws_pkg::DEF_ENTRIES
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [iqws_pkg::CNT_W-1:0]          csr_entry_count,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_operation,
   input  logic [iqws_pkg::ID_W-1:0]           req_entry_index,
   input  logic [iqws_pkg::LAT_W-1:0]          req_entry_latency,
   input  logic [iqws_pkg::SRC_CNT_W-1:0]      req_source_count,
   input  logic [iqws_pkg::ID_W-1:0]           req_source_a,
   input  logic [iqws_pkg::ID_W-1:0]           req_source_b,
   input  logic [iqws_pkg::COMPLETE_LANES-1:0] req_done_mask,
   input  logic [iqws_pkg::ID_W-1:0]           req_done_id0,
   input  logic [iqws_pkg::ID_W-1:0]           req_done_id1,
   input  logic [iqws_pkg::ID_W-1:0]           req_done_id2,
   input  logic [iqws_pkg::ID_W-1:0]           req_done_id3,
   input  logic                                req_out_ready,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_issue_valid,
   output logic [iqws_pkg::ID_W-1:0]           rsp_issue_id,
   output logic [iqws_pkg::LAT_W-1:0]          rsp_issue_latency,
   output logic                                rsp_woke_this_tick,
   output logic                                rsp_stalled,
   output logic                                rsp_all_issued,
   output logic                                rsp_all_completed
);

   iqws_pkg::cmd_type    cmd;
   iqws_pkg::status_type status;

   // Configuration writes are taken whenever out of reset
   assign csr_ready = !reset;

   iqws_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .cmd           (cmd),
      .status        (status)
   );

   iqws_datapath #(
      .ENTRIES (ENTRIES)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_write          (csr_valid && csr_ready),
      .csr_entry_count    (csr_entry_count),
      .req_entry_index    (req_entry_index),
      .req_entry_latency  (req_entry_latency),
      .req_source_count   (req_source_count),
      .req_source_a       (req_source_a),
      .req_source_b       (req_source_b),
      .req_done_mask      (req_done_mask),
      .req_done_id0       (req_done_id0),
      .req_done_id1       (req_done_id1),
      .req_done_id2       (req_done_id2),
      .req_done_id3       (req_done_id3),
      .req_out_ready      (req_out_ready),
      .rsp_issue_valid    (rsp_issue_valid),
      .rsp_issue_id       (rsp_issue_id),
      .rsp_issue_latency  (rsp_issue_latency),
      .rsp_woke_this_tick (rsp_woke_this_tick),
      .rsp_stalled        (rsp_stalled),
      .rsp_all_issued     (rsp_all_issued),
      .rsp_all_completed  (rsp_all_completed)
   );

endmodule

### sv/iqws_checker.sv
// Port-level checks for the issue queue top level, attached by bind.
// Depends on iqws_pkg and issue_queue_wakeup_select_top.
`timescale 1ns / 1ps

module iqws_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic                                rsp_issue_valid,
   input logic [iqws_pkg::ID_W-1:0]           rsp_issue_id,
   input logic [iqws_pkg::LAT_W-1:0]          rsp_issue_latency,
   input logic                                rsp_woke_this_tick,
   input logic                                rsp_stalled
);

   // A stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_issue_id)
         && $stable(rsp_issue_valid) && $stable(rsp_issue_latency))
      else $error("response payload changed while stalled");

   // Issue fields are zero without an issue
   a_no_issue_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_issue_valid |->
         rsp_issue_id == '0 && rsp_issue_latency == '0 && !rsp_woke_this_tick)
      else $error("issue fields set without an issue");

   // A response never both issues and reports a stall
   a_issue_or_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_issue_valid && rsp_stalled))
      else $error("issue and stall flagged together");

   // The queue is busy in the cycle after taking a request
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken back to back");

endmodule

bind issue_queue_wakeup_select_top iqws_checker u_iqws_checker (.*);
